### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the person follow drive mapper.
// Users supply signals named clock and reset in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PFDM_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define PFDM_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define PFDM_ASSERT_IMP(label, ante, cons, msg)
`define PFDM_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

### rtl/core/pfdm_pkg.sv
// Shared types and constants of the person follow drive mapper.
// No dependencies; the score and throttle stages and the top level refer to this package.
`default_nettype none

package pfdm_pkg;

   // Register indexes of the configuration port.
   localparam logic [2:0] CSR_IDLE_PWM    = 3'd0;
   localparam logic [2:0] CSR_SCORE_FAR   = 3'd1;
   localparam logic [2:0] CSR_SCORE_SLOW  = 3'd2;
   localparam logic [2:0] CSR_SCORE_STOP  = 3'd3;
   localparam logic [2:0] CSR_FEET_FAR    = 3'd4;
   localparam logic [2:0] CSR_FEET_SLOW   = 3'd5;
   localparam logic [2:0] CSR_FEET_STOP   = 3'd6;
   localparam logic [2:0] CSR_TURN_GAIN   = 3'd7;

   // Pseudo-score constants, Q0.16: 0.90 and 0.05.
   localparam logic [15:0] PSEUDO_NEAR   = 16'd58982;
   localparam logic [15:0] PSEUDO_MARGIN = 16'd3277;

   // How the score of a request is formed.
   localparam logic [1:0] PMODE_DIRECT = 2'd0;
   localparam logic [1:0] PMODE_NEAR   = 2'd1;
   localparam logic [1:0] PMODE_INTERP = 2'd2;
   localparam logic [1:0] PMODE_LOW    = 2'd3;

   // Throttle zones.
   localparam logic [1:0] ZONE_NEUTRAL = 2'd0;
   localparam logic [1:0] ZONE_FULL    = 2'd1;
   localparam logic [1:0] ZONE_RAMP    = 2'd2;
   localparam logic [1:0] ZONE_DECAY   = 2'd3;

   typedef struct packed {
      logic [15:0] idle_pwm;
      logic [15:0] score_far;
      logic [15:0] score_slow;
      logic [15:0] score_stop;
      logic [7:0]  feet_far;
      logic [7:0]  feet_slow;
      logic [7:0]  feet_stop;
      logic [15:0] turn_gain;
   } cfg_type;

   typedef struct packed {
      logic        has_person;
      logic [7:0]  cx;
      logic [7:0]  feet_y;
      logic [15:0] dist_score;
   } req_type;

   // Travels beside the pseudo-score division.
   typedef struct packed {
      logic               has_person;
      logic [1:0]         mode;
      logic               neg;
      logic [15:0]        value;
      logic               steer_dead;
      logic signed [25:0] steer_prod;
   } score_side_type;

   // Between the score stage and the throttle stage.
   typedef struct packed {
      logic        has_person;
      logic [15:0] score;
      logic [15:0] steering;
   } mid_type;

   // Travels beside the throttle division.
   typedef struct packed {
      logic        has_person;
      logic [1:0]  zone;
      logic [15:0] steering;
   } thr_side_type;

endpackage

`default_nettype wire

### rtl/core/pfdm_req_if.sv
// Request channel of the person follow drive mapper: valid, ready and payload.
// No dependencies.
`default_nettype none

interface pfdm_req_if;
   logic        valid;
   logic        ready;
   logic        has_person;
   logic [7:0]  cx;
   logic [7:0]  feet_y;
   logic [15:0] dist_score;

   modport source (output valid, output has_person, output cx, output feet_y,
                   output dist_score, input ready);
   modport sink (input valid, input has_person, input cx, input feet_y,
                 input dist_score, output ready);
endinterface

`default_nettype wire

### rtl/core/pfdm_rsp_if.sv
// Result channel of the person follow drive mapper: valid, ready and payload.
// No dependencies.
`default_nettype none

interface pfdm_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] throttle;
   logic [15:0] steering;

   modport source (output valid, output throttle, output steering, input ready);
   modport sink (input valid, input throttle, input steering, output ready);
endinterface

`default_nettype wire

### rtl/core/pfdm_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Uses assert_macros.svh; carries a sideband vector beside each request.
`default_nettype none
`include "assert_macros.svh"

module pfdm_div_pipe #(
   parameter int NW = 24,
   parameter int DW = 8,
   parameter int SW = 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          en,
   input  wire logic          in_valid,
   input  wire logic [NW-1:0] in_numer,
   input  wire logic [DW-1:0] in_denom,
   input  wire logic [SW-1:0] in_side,
   output logic               out_valid,
   output logic [NW-1:0]      out_quot,
   output logic [SW-1:0]      out_side
);

   // Each stage holds the partial remainder above the unshifted numerator bits.
   logic [DW+NW-1:0] acc_ff [1:NW];
   logic [DW-1:0]    den_ff [1:NW];
   logic [SW-1:0]    side_ff [1:NW];
   logic             vld_ff [1:NW];

   for (genvar g = 0; g < NW; g++) begin : g_stage
      logic [DW+NW-1:0] src_acc;
      logic [DW-1:0]    src_den;
      logic [SW-1:0]    src_side;
      logic             src_vld;
      logic [DW+NW:0]   shifted;
      logic [DW:0]      top;
      logic [DW:0]      diff;
      logic             take;

      if (g == 0) begin : g_first
         assign src_acc  = {{DW{1'b0}}, in_numer};
         assign src_den  = in_denom;
         assign src_side = in_side;
         assign src_vld  = in_valid;
      end else begin : g_next
         assign src_acc  = acc_ff[g];
         assign src_den  = den_ff[g];
         assign src_side = side_ff[g];
         assign src_vld  = vld_ff[g];
      end

      assign shifted = {src_acc, 1'b0};
      assign top     = shifted[DW+NW:NW];
      assign diff    = top - {1'b0, src_den};
      assign take    = (top >= {1'b0, src_den});

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g+1] <= 1'b0;
         end else if (en) begin
            vld_ff[g+1] <= src_vld;
         end
         if (en) begin
            acc_ff[g+1]  <= take ? {diff[DW-1:0], shifted[NW-1:1], 1'b1}
                                 : shifted[DW+NW-1:0];
            den_ff[g+1]  <= src_den;
            side_ff[g+1] <= src_side;
         end
      end
   end

   assign out_valid = vld_ff[NW];
   assign out_quot  = acc_ff[NW][NW-1:0];
   assign out_side  = side_ff[NW];

   `PFDM_ASSERT_IMP(a_rem_below_den, vld_ff[NW] && (den_ff[NW] != '0), acc_ff[NW][DW+NW-1:NW] < den_ff[NW], "remainder not below divisor")
   `PFDM_ASSERT_NXT(a_stall_holds_quot, !en, $stable(out_quot) && $stable(out_side), "result moved during stall")
   `PFDM_ASSERT_NXT(a_stall_holds_valid, !en, $stable(out_valid), "valid moved during stall")

endmodule

`default_nettype wire

### rtl/core/pfdm_score_map.sv
// Score stage: forms the Q0.16 score (direct or from the feet row) and steering.
// Depends on pfdm_pkg and pfdm_div_pipe.
`default_nettype none

module pfdm_score_map #(
   parameter int MAX_STEER     = 400,
   parameter int CENTRE_DEAD   = 8,
   parameter int CENTRE_COLUMN = 96
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire pfdm_pkg::cfg_type cfg,
   input  wire logic              in_valid,
   input  wire pfdm_pkg::req_type in_req,
   output logic                   mid_valid,
   output pfdm_pkg::mid_type      mid
);

   localparam int SW = $bits(pfdm_pkg::score_side_type);

   // Front stage: zone of the feet row, the interpolation product and steering product.
   logic                     near_z, slow_z, far_z;
   logic signed [16:0]       sdiff;
   logic [15:0]              smag;
   logic [7:0]               fdiff;
   logic signed [8:0]        off;
   logic [8:0]               off_mag;
   pfdm_pkg::score_side_type side_in;
   logic [23:0]              numer_in;
   logic [7:0]               denom_in;

   always_comb begin
      near_z = (in_req.feet_y >= cfg.feet_stop);
      slow_z = (in_req.feet_y >= cfg.feet_slow);
      far_z  = (in_req.feet_y >= cfg.feet_far);
      sdiff  = slow_z ? ($signed({1'b0, cfg.score_stop}) - $signed({1'b0, cfg.score_slow}))
                      : ($signed({1'b0, cfg.score_slow}) - $signed({1'b0, cfg.score_far}));
      smag   = sdiff[16] ? 16'(-sdiff) : sdiff[15:0];
      fdiff  = slow_z ? (in_req.feet_y - cfg.feet_slow) : (in_req.feet_y - cfg.feet_far);
      numer_in = smag * fdiff;
      denom_in = slow_z ? (cfg.feet_stop - cfg.feet_slow) : (cfg.feet_slow - cfg.feet_far);

      side_in.has_person = in_req.has_person;
      side_in.neg        = sdiff[16];
      if (in_req.dist_score != '0) begin
         side_in.mode  = pfdm_pkg::PMODE_DIRECT;
         side_in.value = in_req.dist_score;
      end else if (near_z) begin
         side_in.mode  = pfdm_pkg::PMODE_NEAR;
         side_in.value = pfdm_pkg::PSEUDO_NEAR;
      end else if (slow_z || far_z) begin
         // The slow segment is tested before the far one.
         side_in.mode  = pfdm_pkg::PMODE_INTERP;
         side_in.value = slow_z ? cfg.score_slow : cfg.score_far;
      end else begin
         side_in.mode  = pfdm_pkg::PMODE_LOW;
         side_in.value = (cfg.score_far >= pfdm_pkg::PSEUDO_MARGIN)
                         ? (cfg.score_far - pfdm_pkg::PSEUDO_MARGIN) : 16'd0;
      end

      off     = $signed({1'b0, in_req.cx}) - $signed(9'(CENTRE_COLUMN));
      off_mag = off[8] ? 9'(-off) : off;
      side_in.steer_dead = (off_mag <= 9'(CENTRE_DEAD));
      side_in.steer_prod = off * $signed({1'b0, cfg.turn_gain});
   end

   logic                  s1_valid_ff;
   logic [23:0]           s1_numer_ff;
   logic [7:0]            s1_denom_ff;
   logic [SW-1:0]         s1_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
      end
      if (en) begin
         s1_numer_ff <= numer_in;
         s1_denom_ff <= denom_in;
         s1_side_ff  <= side_in;
      end
   end

   logic                     dv_valid;
   logic [23:0]              dv_quot;
   logic [SW-1:0]            dv_side_bits;
   pfdm_pkg::score_side_type dv_side;

   pfdm_div_pipe #(.NW(24), .DW(8), .SW(SW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s1_valid_ff),
      .in_numer  (s1_numer_ff),
      .in_denom  (s1_denom_ff),
      .in_side   (s1_side_ff),
      .out_valid (dv_valid),
      .out_quot  (dv_quot),
      .out_side  (dv_side_bits)
   );

   assign dv_side = dv_side_bits;

   // Back stage: finish the pseudo-score and the clamped steering.
   logic signed [25:0] q_s, v_s;
   logic [15:0]        score;
   logic signed [25:0] st_t;
   logic signed [17:0] st_q;
   logic signed [19:0] st_sum, st_hi, st_lo, st_clamp;
   logic [15:0]        st_sat;
   pfdm_pkg::mid_type  mid_in;

   always_comb begin
      q_s = $signed({2'b00, dv_quot});
      v_s = $signed({10'd0, dv_side.value}) + (dv_side.neg ? -q_s : q_s);
      unique case (dv_side.mode)
         pfdm_pkg::PMODE_INTERP: begin
            if (v_s < 0) begin
               score = 16'd0;
            end else if (v_s > 26'sd65535) begin
               score = 16'hFFFF;
            end else begin
               score = v_s[15:0];
            end
         end
         default: score = dv_side.value;
      endcase

      st_t   = dv_side.steer_prod + (dv_side.steer_prod[25] ? 26'sd255 : 26'sd0);
      st_q   = st_t[25:8];
      st_sum = $signed({4'd0, cfg.idle_pwm}) + {{2{st_q[17]}}, st_q};
      st_hi  = $signed({4'd0, cfg.idle_pwm}) + $signed(20'(MAX_STEER));
      st_lo  = $signed({4'd0, cfg.idle_pwm}) - $signed(20'(MAX_STEER));
      if (st_sum > st_hi) begin
         st_clamp = st_hi;
      end else if (st_sum < st_lo) begin
         st_clamp = st_lo;
      end else begin
         st_clamp = st_sum;
      end
      if (st_clamp < 0) begin
         st_sat = 16'd0;
      end else if (st_clamp > 20'sd65535) begin
         st_sat = 16'hFFFF;
      end else begin
         st_sat = st_clamp[15:0];
      end

      mid_in.has_person = dv_side.has_person;
      mid_in.score      = score;
      mid_in.steering   = (dv_side.steer_dead || (score >= cfg.score_slow))
                          ? cfg.idle_pwm : st_sat;
   end

   logic              mid_valid_ff;
   pfdm_pkg::mid_type mid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
      end else if (en) begin
         mid_valid_ff <= dv_valid;
      end
      if (en) begin
         mid_ff <= mid_in;
      end
   end

   assign mid_valid = mid_valid_ff;
   assign mid       = mid_ff;

endmodule

`default_nettype wire

### rtl/core/pfdm_throttle_map.sv
// Throttle stage: picks the zone, divides for the ramp or decay and forms the PWM.
// Depends on pfdm_pkg and pfdm_div_pipe.
`default_nettype none

module pfdm_throttle_map #(
   parameter int MAX_THROTTLE  = 400,
   parameter int THROTTLE_DEAD = 10
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire pfdm_pkg::cfg_type cfg,
   input  wire logic              mid_valid,
   input  wire pfdm_pkg::mid_type mid,
   output logic                   out_valid,
   output logic [15:0]            out_throttle,
   output logic [15:0]            out_steering
);

   localparam int RAMP_K = MAX_THROTTLE - 100;
   localparam int TK     = (RAMP_K > 100) ? RAMP_K : 100;
   localparam int KW     = $clog2(TK + 1);
   localparam int TNW    = 16 + KW;
   localparam int QW     = $clog2(MAX_THROTTLE + 1);
   localparam int SW     = $bits(pfdm_pkg::thr_side_type);

   pfdm_pkg::thr_side_type side_in;
   logic [15:0]            sdiff;
   logic [KW-1:0]          coef;
   logic [15:0]            denom_in;
   logic [TNW-1:0]         numer_in;

   always_comb begin
      side_in.has_person = mid.has_person;
      side_in.steering   = mid.steering;
      if (mid.score >= cfg.score_stop) begin
         side_in.zone = pfdm_pkg::ZONE_NEUTRAL;
      end else if (mid.score < cfg.score_far) begin
         side_in.zone = pfdm_pkg::ZONE_FULL;
      end else if (mid.score < cfg.score_slow) begin
         side_in.zone = pfdm_pkg::ZONE_RAMP;
      end else begin
         side_in.zone = pfdm_pkg::ZONE_DECAY;
      end
      if (side_in.zone == pfdm_pkg::ZONE_RAMP) begin
         sdiff    = mid.score - cfg.score_far;
         coef     = KW'(RAMP_K);
         denom_in = cfg.score_slow - cfg.score_far;
      end else begin
         sdiff    = cfg.score_stop - mid.score;
         coef     = KW'(100);
         denom_in = cfg.score_stop - cfg.score_slow;
      end
      numer_in = sdiff * coef;
   end

   logic           s3_valid_ff;
   logic [TNW-1:0] s3_numer_ff;
   logic [15:0]    s3_denom_ff;
   logic [SW-1:0]  s3_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= mid_valid;
      end
      if (en) begin
         s3_numer_ff <= numer_in;
         s3_denom_ff <= denom_in;
         s3_side_ff  <= side_in;
      end
   end

   logic                   dv_valid;
   logic [TNW-1:0]         dv_quot;
   logic [SW-1:0]          dv_side_bits;
   pfdm_pkg::thr_side_type dv_side;

   pfdm_div_pipe #(.NW(TNW), .DW(16), .SW(SW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s3_valid_ff),
      .in_numer  (s3_numer_ff),
      .in_denom  (s3_denom_ff),
      .in_side   (s3_side_ff),
      .out_valid (dv_valid),
      .out_quot  (dv_quot),
      .out_side  (dv_side_bits)
   );

   assign dv_side = dv_side_bits;

   // Quotients in use stay below MAX_THROTTLE, so QW bits hold them.
   logic [QW-1:0]      q;
   logic signed [19:0] off;
   logic signed [19:0] sum;

   always_comb begin
      q = dv_quot[QW-1:0];
      unique case (dv_side.zone)
         pfdm_pkg::ZONE_NEUTRAL: off = 20'sd0;
         pfdm_pkg::ZONE_FULL:    off = $signed(20'(MAX_THROTTLE));
         pfdm_pkg::ZONE_RAMP:    off = $signed(20'(MAX_THROTTLE)) - $signed({{(20-QW){1'b0}}, q});
         default: begin
            off = (q <= QW'(THROTTLE_DEAD)) ? 20'sd0 : $signed({{(20-QW){1'b0}}, q});
         end
      endcase
      sum = $signed({4'd0, cfg.idle_pwm}) + off;
      if (!dv_side.has_person) begin
         out_throttle = cfg.idle_pwm;
         out_steering = cfg.idle_pwm;
      end else begin
         if (sum < 0) begin
            out_throttle = 16'd0;
         end else if (sum > 20'sd65535) begin
            out_throttle = 16'hFFFF;
         end else begin
            out_throttle = sum[15:0];
         end
         out_steering = dv_side.steering;
      end
   end

   assign out_valid = dv_valid;

endmodule

`default_nettype wire

### rtl/core/person_follow_drive_mapper.sv
// Person follow drive mapper: turns one person detection into a throttle and
// steering PWM pair. Depends on pfdm_pkg, the two channel interfaces and the
// score and throttle stages.
`default_nettype none

// Each request carries a detection (has_person, cx, feet_y, dist_score) and
// yields exactly one response (throttle, steering), in order. The block is a
// fully pipelined datapath: a request can be accepted on every clock unless the
// response side stalls. Between acceptance and the response lie the score input
// register, the 24-stage feet-row interpolation divider, the mid register, the
// throttle input register, the 16 + clog2 stage ramp or decay divider and the
// response register. Both dividers are pipelined restoring ones with one
// quotient bit per stage. The whole pipeline advances together whenever the
// response register is empty or being taken, so back-pressure on the response
// side stalls it without loss, and req_bus.ready is low only while a finished
// response waits. Configuration is written through csr_write_enable,
// csr_index and csr_write_data and must only be changed while no request is in
// flight. Threshold registers are expected to be ordered (far below slow below
// stop); otherwise the outputs remain defined but are not meaningful. Both
// outputs saturate to 0..65535.
module person_follow_drive_mapper #(
   parameter int MAX_THROTTLE  = 400,
   parameter int MAX_STEER     = 400,
   parameter int THROTTLE_DEAD = 10,
   parameter int CENTRE_DEAD   = 8,
   parameter int CENTRE_COLUMN = 96
) (
   input  wire logic        clock,
   input  wire logic        reset,
   pfdm_req_if.sink         req_bus,
   pfdm_rsp_if.source       rsp_bus,
   input  wire logic        csr_write_enable,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_write_data
);

   // Configuration registers, loaded with their documented reset values.
   pfdm_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.idle_pwm    <= 16'd1500;
         cfg_ff.score_far   <= 16'd19661;
         cfg_ff.score_slow  <= 16'd39322;
         cfg_ff.score_stop  <= 16'd52429;
         cfg_ff.feet_far    <= 8'd60;
         cfg_ff.feet_slow   <= 8'd100;
         cfg_ff.feet_stop   <= 8'd130;
         cfg_ff.turn_gain   <= 16'd512;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            pfdm_pkg::CSR_IDLE_PWM:    cfg_ff.idle_pwm    <= csr_write_data;
            pfdm_pkg::CSR_SCORE_FAR:   cfg_ff.score_far   <= csr_write_data;
            pfdm_pkg::CSR_SCORE_SLOW:  cfg_ff.score_slow  <= csr_write_data;
            pfdm_pkg::CSR_SCORE_STOP:  cfg_ff.score_stop  <= csr_write_data;
            pfdm_pkg::CSR_FEET_FAR:    cfg_ff.feet_far    <= csr_write_data[7:0];
            pfdm_pkg::CSR_FEET_SLOW:   cfg_ff.feet_slow   <= csr_write_data[7:0];
            pfdm_pkg::CSR_FEET_STOP:   cfg_ff.feet_stop   <= csr_write_data[7:0];
            pfdm_pkg::CSR_TURN_GAIN:   cfg_ff.turn_gain   <= csr_write_data;
         endcase
      end
   end

   // The pipeline moves as one whenever the response register can take a value.
   logic rsp_valid_ff;
   logic en;

   assign en            = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = en;

   pfdm_pkg::req_type req_in;

   assign req_in.has_person = req_bus.has_person;
   assign req_in.cx         = req_bus.cx;
   assign req_in.feet_y     = req_bus.feet_y;
   assign req_in.dist_score = req_bus.dist_score;

   logic              mid_valid;
   pfdm_pkg::mid_type mid;

   pfdm_score_map #(
      .MAX_STEER     (MAX_STEER),
      .CENTRE_DEAD   (CENTRE_DEAD),
      .CENTRE_COLUMN (CENTRE_COLUMN)
   ) u_score (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (cfg_ff),
      .in_valid  (req_bus.valid),
      .in_req    (req_in),
      .mid_valid (mid_valid),
      .mid       (mid)
   );

   logic        thr_valid;
   logic [15:0] thr_throttle;
   logic [15:0] thr_steering;

   pfdm_throttle_map #(
      .MAX_THROTTLE  (MAX_THROTTLE),
      .THROTTLE_DEAD (THROTTLE_DEAD)
   ) u_throttle (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .cfg          (cfg_ff),
      .mid_valid    (mid_valid),
      .mid          (mid),
      .out_valid    (thr_valid),
      .out_throttle (thr_throttle),
      .out_steering (thr_steering)
   );

   // Response register: holds a finished response until it is taken.
   logic [15:0] rsp_throttle_ff;
   logic [15:0] rsp_steering_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= thr_valid;
      end
      if (en) begin
         rsp_throttle_ff <= thr_throttle;
         rsp_steering_ff <= thr_steering;
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.throttle = rsp_throttle_ff;
   assign rsp_bus.steering = rsp_steering_ff;

endmodule

`default_nettype wire

### sim/person_follow_drive_mapper_tb.sv
// Self-checking testbench of the person follow drive mapper: a drive-command
// predictor in a small scoreboard class, random stimulus and random stalls.
// Depends on pfdm_pkg, pfdm_req_if, pfdm_rsp_if and the mapper RTL.
`timescale 1ns / 100ps

module person_follow_drive_mapper_tb;

   localparam int MAX_THR = 400;
   localparam int MAX_STR = 400;
   localparam int THR_DEAD = 10;
   localparam int CTR_DEAD = 8;
   localparam int CTR_COL = 96;
   localparam int LATENCY = 53;
   localparam int CYCLE_LIMIT = 600000;
   localparam int RANDOM_REQUESTS = 1900;

   typedef struct {
      logic [15:0] throttle;
      logic [15:0] steering;
   } drive_cmd_type;

   // Predicts the drive command of each request and checks responses in order.
   class drive_scoreboard;
      pfdm_pkg::cfg_type cfg;
      drive_cmd_type pending[$];
      int mismatches;
      int checked;

      function void reset_cfg();
         cfg.idle_pwm = 16'd1500;
         cfg.score_far = 16'd19661;
         cfg.score_slow = 16'd39322;
         cfg.score_stop = 16'd52429;
         cfg.feet_far = 8'd60;
         cfg.feet_slow = 8'd100;
         cfg.feet_stop = 8'd130;
         cfg.turn_gain = 16'd512;
         mismatches = 0;
         checked = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [15:0] data);
         case (idx)
            pfdm_pkg::CSR_IDLE_PWM: cfg.idle_pwm = data;
            pfdm_pkg::CSR_SCORE_FAR: cfg.score_far = data;
            pfdm_pkg::CSR_SCORE_SLOW: cfg.score_slow = data;
            pfdm_pkg::CSR_SCORE_STOP: cfg.score_stop = data;
            pfdm_pkg::CSR_FEET_FAR: cfg.feet_far = data[7:0];
            pfdm_pkg::CSR_FEET_SLOW: cfg.feet_slow = data[7:0];
            pfdm_pkg::CSR_FEET_STOP: cfg.feet_stop = data[7:0];
            pfdm_pkg::CSR_TURN_GAIN: cfg.turn_gain = data;
         endcase
      endfunction

      function longint sat16(longint v);
         if (v < 0) return 0;
         if (v > 65535) return 65535;
         return v;
      endfunction

      // All arithmetic is done on signed 64-bit copies of the registers.
      function longint pseudo_score(longint f);
         longint v, sfar, sslow, sstop, ffar, fslow, fstop;
         sfar = longint'(cfg.score_far);
         sslow = longint'(cfg.score_slow);
         sstop = longint'(cfg.score_stop);
         ffar = longint'(cfg.feet_far);
         fslow = longint'(cfg.feet_slow);
         fstop = longint'(cfg.feet_stop);
         if (f >= fstop) return longint'(pfdm_pkg::PSEUDO_NEAR);
         if (f >= fslow) begin
            v = sslow + ((sstop - sslow) * (f - fslow)) / (fstop - fslow);
            return sat16(v);
         end
         if (f >= ffar) begin
            v = sfar + ((sslow - sfar) * (f - ffar)) / (fslow - ffar);
            return sat16(v);
         end
         v = sfar - longint'(pfdm_pkg::PSEUDO_MARGIN);
         return v < 0 ? 0 : v;
      endfunction

      function longint throttle_pwm(longint s);
         longint n, off, sfar, sslow, sstop;
         n = longint'(cfg.idle_pwm);
         sfar = longint'(cfg.score_far);
         sslow = longint'(cfg.score_slow);
         sstop = longint'(cfg.score_stop);
         if (s >= sstop) return sat16(n);
         if (s < sfar) return sat16(n + MAX_THR);
         if (s < sslow) begin
            off = MAX_THR - ((s - sfar) * (MAX_THR - 100)) / (sslow - sfar);
            return sat16(n + off);
         end
         off = (100 * (sstop - s)) / (sstop - sslow);
         if (off <= THR_DEAD) off = 0;
         return sat16(n + off);
      endfunction

      function longint steering_pwm(longint cx);
         longint n, off, st;
         n = longint'(cfg.idle_pwm);
         off = cx - CTR_COL;
         if ((off < 0 ? -off : off) <= CTR_DEAD) return sat16(n);
         st = n + (off * longint'(cfg.turn_gain)) / 256;
         if (st > n + MAX_STR) st = n + MAX_STR;
         if (st < n - MAX_STR) st = n - MAX_STR;
         return sat16(st);
      endfunction

      // Notes an accepted request and queues the command it must produce.
      function void note_request(pfdm_pkg::req_type r);
         drive_cmd_type c;
         longint s;
         if (!r.has_person) begin
            c.throttle = cfg.idle_pwm;
            c.steering = cfg.idle_pwm;
         end else begin
            s = longint'(r.dist_score);
            if (s == 0) s = pseudo_score(longint'(r.feet_y));
            c.steering = 16'(steering_pwm(longint'(r.cx)));
            if (s >= longint'(cfg.score_slow)) c.steering = cfg.idle_pwm;
            c.throttle = 16'(throttle_pwm(s));
         end
         pending.push_back(c);
      endfunction

      function void check_response(logic [15:0] thr, logic [15:0] str);
         drive_cmd_type c;
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected response thr=%0d str=%0d", thr, str);
            return;
         end
         c = pending.pop_front();
         if (thr !== c.throttle || str !== c.steering) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Mismatch: throttle exp %0d got %0d, steering exp %0d got %0d",
                        c.throttle, thr, c.steering, str);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [2:0] csr_index = pfdm_pkg::CSR_IDLE_PWM;
   logic [15:0] csr_write_data = '0;
   int cycles = 0;
   int requests_sent = 0;
   bit send_done = 1'b0;

   drive_scoreboard sb;

   pfdm_req_if req_bus ();
   pfdm_rsp_if rsp_bus ();

   person_follow_drive_mapper DUT (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly short gaps with an occasional long one.
   function automatic int gap_length();
      int p;
      p = $urandom_range(0, 99);
      if (p < 40) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   initial begin
      req_bus.valid = 1'b0;
      req_bus.has_person = 1'b0;
      req_bus.cx = '0;
      req_bus.feet_y = '0;
      req_bus.dist_score = '0;
      rsp_bus.ready = 1'b0;
   end

   // Every accepted request is predicted at the rising edge it is taken.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && req_bus.valid && req_bus.ready)
         sb.note_request({req_bus.has_person, req_bus.cx, req_bus.feet_y, req_bus.dist_score});
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_response(rsp_bus.throttle, rsp_bus.steering);
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // The response side stalls at random, with some stretches of constant ready.
   initial begin
      int n;
      wait (!reset);
      forever begin
         if ($urandom_range(0, 9) == 0) begin
            @(negedge clock) rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(20, 80)) @(negedge clock);
         end
         n = gap_length();
         if (n > 0) begin
            @(negedge clock) rsp_bus.ready <= 1'b0;
            repeat (n - 1) @(negedge clock);
         end
         @(negedge clock) rsp_bus.ready <= 1'b1;
      end
   end

   task automatic write_csr(logic [2:0] idx, logic [15:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Holds one request until accepted; gap decides whether valid drops between them.
   task automatic send_request(logic hp, logic [7:0] cx, logic [7:0] fy, logic [15:0] ds,
                               int gap);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.has_person <= hp;
      req_bus.cx <= cx;
      req_bus.feet_y <= fy;
      req_bus.dist_score <= ds;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      requests_sent++;
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   // Random request: scores cluster near the thresholds so every zone boundary is hit.
   task automatic random_request();
      logic [15:0] ds;
      logic [7:0] fy;
      int p;
      p = $urandom_range(0, 9);
      if (p < 3) ds = 16'd0;
      else if (p < 7) begin
         case ($urandom_range(0, 2))
            0: ds = sb.cfg.score_far + 16'($urandom_range(0, 8)) - 16'd4;
            1: ds = sb.cfg.score_slow + 16'($urandom_range(0, 8)) - 16'd4;
            default: ds = sb.cfg.score_stop + 16'($urandom_range(0, 8)) - 16'd4;
         endcase
      end else ds = 16'($urandom);
      if ($urandom_range(0, 1)) fy = 8'($urandom);
      else fy = sb.cfg.feet_far + 8'($urandom_range(0, 80)) - 8'd5;
      send_request($urandom_range(0, 7) != 0, 8'($urandom), fy, ds, gap_length());
   endtask

   initial begin
      int i, ph;
      sb = new();
      sb.reset_cfg();
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Directed requests under the reset configuration: extremes of every field,
      // each throttle zone, the feet-row mapping and the steering deadband edges.
      send_request(1'b0, 8'd255, 8'd255, 16'hFFFF, 0);
      send_request(1'b1, 8'd0, 8'd0, 16'd1, 0);
      send_request(1'b1, 8'd255, 8'd0, 16'hFFFF, 0);
      send_request(1'b1, 8'd104, 8'd0, 16'd19660, 0);
      send_request(1'b1, 8'd105, 8'd0, 16'd19661, 0);
      send_request(1'b1, 8'd88, 8'd0, 16'd39321, 0);
      send_request(1'b1, 8'd87, 8'd0, 16'd39322, 0);
      send_request(1'b1, 8'd150, 8'd0, 16'd50000, 0);
      send_request(1'b1, 8'd40, 8'd0, 16'd52428, 1);
      send_request(1'b1, 8'd96, 8'd0, 16'd52429, 0);
      send_request(1'b1, 8'd200, 8'd0, 16'd0, 0);
      send_request(1'b1, 8'd10, 8'd59, 16'd0, 0);
      send_request(1'b1, 8'd120, 8'd60, 16'd0, 0);
      send_request(1'b1, 8'd70, 8'd80, 16'd0, 0);
      send_request(1'b1, 8'd130, 8'd100, 16'd0, 0);
      send_request(1'b1, 8'd97, 8'd129, 16'd0, 2);
      send_request(1'b1, 8'd240, 8'd130, 16'd0, 0);
      send_request(1'b1, 8'd1, 8'd255, 16'd0, 0);
      send_request(1'b1, 8'd85, 8'hAA, 16'h5555, 0);
      send_request(1'b1, 8'hAA, 8'h55, 16'hAAAA, 0);
      drain();

      // Phases under several configurations: saturating neutral values, gains,
      // score_far below the margin, unordered thresholds and random settings.
      for (ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin
               write_csr(pfdm_pkg::CSR_IDLE_PWM, 16'd0);
               write_csr(pfdm_pkg::CSR_TURN_GAIN, 16'hFFFF);
               write_csr(pfdm_pkg::CSR_SCORE_FAR, 16'd1000);
            end
            1: begin
               write_csr(pfdm_pkg::CSR_IDLE_PWM, 16'hFFFF);
               write_csr(pfdm_pkg::CSR_TURN_GAIN, 16'd0);
               write_csr(pfdm_pkg::CSR_FEET_FAR, 8'd0);
               write_csr(pfdm_pkg::CSR_FEET_SLOW, 8'd1);
               write_csr(pfdm_pkg::CSR_FEET_STOP, 8'd255);
            end
            2: begin
               write_csr(pfdm_pkg::CSR_IDLE_PWM, 16'd65300);
               write_csr(pfdm_pkg::CSR_SCORE_FAR, 16'd0);
               write_csr(pfdm_pkg::CSR_SCORE_SLOW, 16'd1);
               write_csr(pfdm_pkg::CSR_SCORE_STOP, 16'hFFFF);
               write_csr(pfdm_pkg::CSR_TURN_GAIN, 16'd300);
            end
            3: begin
               write_csr(pfdm_pkg::CSR_IDLE_PWM, 16'd200);
               write_csr(pfdm_pkg::CSR_SCORE_FAR, 16'd50000);
               write_csr(pfdm_pkg::CSR_SCORE_SLOW, 16'd20000);
               write_csr(pfdm_pkg::CSR_SCORE_STOP, 16'd10000);
               write_csr(pfdm_pkg::CSR_FEET_FAR, 8'd200);
               write_csr(pfdm_pkg::CSR_FEET_SLOW, 8'd100);
               write_csr(pfdm_pkg::CSR_FEET_STOP, 8'd50);
            end
            4: begin
               write_csr(pfdm_pkg::CSR_SCORE_FAR, 16'd30000);
               write_csr(pfdm_pkg::CSR_SCORE_SLOW, 16'd30000);
               write_csr(pfdm_pkg::CSR_SCORE_STOP, 16'd30000);
               write_csr(pfdm_pkg::CSR_FEET_FAR, 8'd90);
               write_csr(pfdm_pkg::CSR_FEET_SLOW, 8'd90);
               write_csr(pfdm_pkg::CSR_FEET_STOP, 8'd90);
            end
            default: begin
               write_csr(pfdm_pkg::CSR_IDLE_PWM, 16'($urandom_range(0, 3000)));
               write_csr(pfdm_pkg::CSR_SCORE_FAR, 16'($urandom_range(0, 25000)));
               write_csr(pfdm_pkg::CSR_SCORE_SLOW, 16'($urandom_range(25001, 45000)));
               write_csr(pfdm_pkg::CSR_SCORE_STOP, 16'($urandom_range(45001, 65535)));
               write_csr(pfdm_pkg::CSR_FEET_FAR, 8'($urandom_range(0, 80)));
               write_csr(pfdm_pkg::CSR_FEET_SLOW, 8'($urandom_range(81, 160)));
               write_csr(pfdm_pkg::CSR_FEET_STOP, 8'($urandom_range(161, 255)));
               write_csr(pfdm_pkg::CSR_TURN_GAIN, 16'($urandom_range(0, 4000)));
            end
         endcase
         for (i = 0; i < RANDOM_REQUESTS / 8; i++) random_request();
         drain();
      end

      $display("Covered %0d requests, %0d responses checked, over 9 register settings.",
               requests_sent, sb.checked);
      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### files.f
+incdir+rtl/core
rtl/core/pfdm_pkg.sv
rtl/core/pfdm_req_if.sv
rtl/core/pfdm_rsp_if.sv
rtl/core/pfdm_div_pipe.sv
rtl/core/pfdm_score_map.sv
rtl/core/pfdm_throttle_map.sv
rtl/core/person_follow_drive_mapper.sv
sim/person_follow_drive_mapper_tb.sv
